>>> sv/spmq_pkg.sv
// spmq_pkg: types and constants of the strict priority multi queue
// request and result structs, status and kind codes, queue geometry
// no dependencies
package spmq_pkg;

  localparam int unsigned Levels     = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TagWidth   = 16;

  localparam int unsigned LvlW   = $clog2(Levels);
  localparam int unsigned PtrW   = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW  = $clog2(Levels * QueueDepth);
  localparam int unsigned TotalW = 7;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [LvlW-1:0]     priority_req;
    logic [TagWidth-1:0] task_tag;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [TagWidth-1:0] popped_tag;
    logic [LvlW-1:0]     popped_level;
    logic [TotalW-1:0]   total_count;
    logic                all_empty;
  } rsp_t;

endpackage

>>> sv/strict_priority_multi_queue.sv
// strict_priority_multi_queue: per-level fifo queues of task tags in one shared tag memory
// depends on spmq_pkg
//
// A request is taken whenever start is high; busy stays low, so one request can be
// issued every cycle. Its result appears on rsp_o, marked by valid_o, for exactly one
// cycle, in the cycle right after the request was taken; the result cannot be held
// off, so the receiver must capture it in that cycle. The result is registered, and a
// popped tag comes from the registered read port of the tag memory. A push to a full
// level is dropped with a full status, and a pop with every level empty returns an
// empty status with a zero tag and level.
module strict_priority_multi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  spmq_pkg::req_t req_i,
  output logic           valid_o,
  output spmq_pkg::rsp_t rsp_o
);
  import spmq_pkg::*;

  logic [TagWidth-1:0] tag_mem [Levels*QueueDepth];
  logic [TagWidth-1:0] rd_q;

  logic [CntW-1:0]   cnt_q  [Levels];
  logic [CntW-1:0]   cnt_d  [Levels];
  logic [PtrW-1:0]   head_q [Levels];
  logic [PtrW-1:0]   head_d [Levels];
  logic [PtrW-1:0]   tail_q [Levels];
  logic [PtrW-1:0]   tail_d [Levels];
  logic [TotalW-1:0] total_q, total_d;

  logic            valid_q, pop_ok_q;
  status_e         status_q, status_d;
  logic [LvlW-1:0] level_q;

  logic            accept, is_push, found, full, do_write, do_read;
  logic [LvlW-1:0] push_lv, pop_lv, sel_lv;
  logic [PtrW-1:0] ptr_sel, ptr_next;
  logic [AddrW-1:0] addr;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign is_push = (req_i.kind == KIND_PUSH);

  always_comb begin
    if (req_i.priority_req >= LvlW'(Levels - 1)) begin
      push_lv = LvlW'(Levels - 1);
    end else begin
      push_lv = req_i.priority_req;
    end
    found  = 1'b0;
    pop_lv = '0;
    for (int l = Levels - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        found  = 1'b1;
        pop_lv = LvlW'(l);
      end
    end
  end

  assign sel_lv   = is_push ? push_lv : pop_lv;
  assign full     = (cnt_q[push_lv] == CntW'(QueueDepth));
  assign do_write = accept & is_push & ~full;
  assign do_read  = accept & ~is_push & found;
  assign ptr_sel  = is_push ? tail_q[sel_lv] : head_q[sel_lv];
  assign ptr_next = (ptr_sel == PtrW'(QueueDepth - 1)) ? '0 : ptr_sel + PtrW'(1);
  assign addr     = AddrW'(AddrW'(sel_lv) * AddrW'(QueueDepth) + AddrW'(ptr_sel));

  always_comb begin
    cnt_d   = cnt_q;
    head_d  = head_q;
    tail_d  = tail_q;
    total_d = total_q;
    if (do_write) begin
      cnt_d[sel_lv]  = cnt_q[sel_lv] + CntW'(1);
      tail_d[sel_lv] = ptr_next;
      total_d        = total_q + TotalW'(1);
    end else if (do_read) begin
      cnt_d[sel_lv]  = cnt_q[sel_lv] - CntW'(1);
      head_d[sel_lv] = ptr_next;
      total_d        = total_q - TotalW'(1);
    end
  end

  always_comb begin
    if (is_push) begin
      status_d = full ? ST_FULL : ST_DONE;
    end else begin
      status_d = found ? ST_DONE : ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Levels; l++) begin
        cnt_q[l]  <= '0;
        head_q[l] <= '0;
        tail_q[l] <= '0;
      end
      total_q  <= '0;
      valid_q  <= 1'b0;
      pop_ok_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      total_q  <= total_d;
      valid_q  <= accept;
      if (accept) begin
        pop_ok_q <= do_read;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      level_q  <= do_read ? pop_lv : '0;
    end
  end

  // tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      tag_mem[addr] <= req_i.task_tag;
    end
    if (do_read) begin
      rd_q <= tag_mem[addr];
    end
  end

  assign valid_o            = valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.popped_tag   = pop_ok_q ? rd_q : '0;
  assign rsp_o.popped_level = level_q;
  assign rsp_o.total_count  = total_q;
  assign rsp_o.all_empty    = (total_q == '0);

endmodule

>>> sv/spmq_checker.sv
// spmq_checker: port-level assertions for strict_priority_multi_queue
// depends on spmq_pkg; bound to the top level at the end of this file
module spmq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input spmq_pkg::req_t req_i,
  input logic           valid_o,
  input spmq_pkg::rsp_t rsp_o
);
  import spmq_pkg::*;

  // one result for each request, in the following cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !valid_o)
    else $error("result without request");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == ST_EMPTY) |->
      (rsp_o.total_count == '0 && rsp_o.all_empty && rsp_o.popped_tag == '0))
    else $error("empty pop with nonzero state");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && rsp_o.status == ST_DONE && $past(req_i.kind) == KIND_POP)
      |-> (rsp_o.total_count == TotalW'($past(rsp_o.total_count) - TotalW'(1))))
    else $error("pop did not lower total count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && rsp_o.status == ST_DONE && $past(req_i.kind) == KIND_PUSH)
      |-> (rsp_o.total_count == TotalW'($past(rsp_o.total_count) + TotalW'(1))))
    else $error("push did not raise total count");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (.*);
